[design/ucd_pkg.sv]
// ucd_pkg: shared constants, codes and types for the configuration
// descriptor endpoint finder. No dependencies.
`default_nettype none

package ucd_pkg;

    // Block size limit and the position counter width that follows from it
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int POS_W           = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int TOTAL_LEN_W     = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CLASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SUBCLASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PROTOCOL = 2'd2;

    // Register reset values
    localparam logic [7:0] RST_MATCH_CLASS    = 8'h03;
    localparam logic [7:0] RST_MATCH_SUBCLASS = 8'h01;
    localparam logic [7:0] RST_MATCH_PROTOCOL = 8'h01;

    // Descriptor types and field masks
    localparam logic [7:0] DT_INTERFACE   = 8'h04;
    localparam logic [7:0] DT_ENDPOINT    = 8'h05;
    localparam logic [7:0] EP_DIR_IN      = 8'h80;
    localparam logic [7:0] EP_NUM_MASK    = 8'h0F;
    localparam logic [7:0] XFER_MASK      = 8'h03;
    localparam logic [7:0] XFER_INTERRUPT = 8'h03;
    localparam logic [7:0] NO_INTERFACE   = 8'hFF;

    // Result choice codes
    localparam logic [1:0] CHOICE_NONE     = 2'd0;
    localparam logic [1:0] CHOICE_PREFER   = 2'd1;
    localparam logic [1:0] CHOICE_FALLBACK = 2'd2;

    typedef struct packed {
        logic [7:0] cls;
        logic [7:0] subclass;
        logic [7:0] protocol;
    } match_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] num;
        logic [15:0] pkt;
        logic [7:0] ifnum;
        logic [7:0] ivl;
    } pick_t;

    typedef struct packed {
        logic [1:0]             choice;
        logic [3:0]             endpoint_number;
        logic [4:0]             endpoint_id;
        logic [15:0]            max_packet;
        logic [7:0]             interface_number;
        logic [7:0]             poll_interval;
        logic [TOTAL_LEN_W-1:0] total_length;
        logic [7:0]             interface_count;
        logic [7:0]             configuration_value;
        logic [7:0]             first_class;
        logic [7:0]             first_subclass;
        logic [7:0]             first_protocol;
    } result_t;

endpackage

`default_nettype wire

[design/ucd_desc_if.sv]
// ucd_desc_if: request channel carrying descriptor bytes.
// Depends on nothing.
`default_nettype none

interface ucd_desc_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[design/ucd_result_if.sv]
// ucd_result_if: request channel carrying the endpoint search result.
// Depends on ucd_pkg for the total length width.
`default_nettype none

interface ucd_result_if;
    import ucd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             choice;
    logic [3:0]             endpoint_number;
    logic [4:0]             endpoint_id;
    logic [15:0]            max_packet;
    logic [7:0]             interface_number;
    logic [7:0]             poll_interval;
    logic [TOTAL_LEN_W-1:0] total_length;
    logic [7:0]             interface_count;
    logic [7:0]             configuration_value;
    logic [7:0]             first_class;
    logic [7:0]             first_subclass;
    logic [7:0]             first_protocol;

    modport source (
        output valid, input ready,
        output choice, output endpoint_number, output endpoint_id, output max_packet,
        output interface_number, output poll_interval, output total_length,
        output interface_count, output configuration_value,
        output first_class, output first_subclass, output first_protocol
    );
    modport sink (
        input valid, output ready,
        input choice, input endpoint_number, input endpoint_id, input max_packet,
        input interface_number, input poll_interval, input total_length,
        input interface_count, input configuration_value,
        input first_class, input first_subclass, input first_protocol
    );
endinterface

`default_nettype wire

[design/usb_config_descriptor_endpoint_finder.sv]
// usb_config_descriptor_endpoint_finder: top level of the endpoint finder.
// A byte marked last reaches the output via the input and result registers.
// Throughput: one byte per cycle; the input register hands a byte to the
// parse logic each cycle; a block end behind an unread result stalls it.
// Reset (rst_n, async, active low): match registers go to 3/1/1, walk state
// and first-interface capture clear, both channels empty.
// Depends on ucd_pkg, ucd_desc_if, ucd_result_if, ucd_in_stage,
// ucd_parse_core and ucd_out_stage.
`default_nettype none

module usb_config_descriptor_endpoint_finder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ucd_desc_if.sink                            desc,
    ucd_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [ucd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ucd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ucd_pkg::*;

    match_t   match_reg;
    match_t   match_next;
    in_item_t item;
    logic     item_valid;
    logic     out_busy;
    logic     advance;
    logic     load;
    result_t  res;

    // Match registers
    always_comb
    begin
        match_next = match_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MATCH_CLASS:    match_next.cls      = cfg_data;
                CFG_MATCH_SUBCLASS: match_next.subclass = cfg_data;
                CFG_MATCH_PROTOCOL: match_next.protocol = cfg_data;
                default:            match_next          = match_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '{cls: RST_MATCH_CLASS, subclass: RST_MATCH_SUBCLASS,
                           protocol: RST_MATCH_PROTOCOL};
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // A held byte moves on unless it ends a block and the result slot is full and unread
    assign advance = item_valid && (!item.last_byte || !out_busy || result.ready);
    assign load    = advance && item.last_byte;

    ucd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    ucd_parse_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .match (match_reg),
        .res   (res)
    );

    ucd_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .res    (res),
        .busy   (out_busy),
        .result (result)
    );

    // No endpoint means no interface and a zero id
    a_none_fields : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.choice == CHOICE_NONE) |->
            (result.interface_number == NO_INTERFACE && result.endpoint_id == 5'd0))
        else $error("empty result carries endpoint fields");

    // A chosen endpoint's id is its number times two plus one
    a_id_form : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.choice != CHOICE_NONE) |->
            (result.endpoint_id == {result.endpoint_number, 1'b1}))
        else $error("endpoint id does not match endpoint number");

    // Configuration value is never reported as zero
    a_cfg_value : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.configuration_value != 8'd0))
        else $error("zero configuration value reported");

    // A block end waiting behind an unread result blocks new bytes
    a_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.last_byte && out_busy && !result.ready) |-> !desc.ready)
        else $error("input taken while block end is stalled");

    // A loaded result shows on the channel next cycle
    a_load : assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("result lost after load");

endmodule

`default_nettype wire

[design/ucd_in_stage.sv]
// ucd_in_stage: input register for descriptor bytes, one request deep.
// Depends on ucd_pkg and ucd_desc_if.
`default_nettype none

module ucd_in_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ucd_desc_if.sink         desc,
    input  wire logic        advance,
    output ucd_pkg::in_item_t item,
    output logic             item_valid
);
    import ucd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // Free when empty or when the held byte moves on this cycle
    assign desc.ready = !valid_reg || advance;
    assign take       = desc.valid && desc.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{data_byte: desc.data_byte, last_byte: desc.last_byte};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

[design/ucd_parse_core.sv]
// ucd_parse_core: descriptor walk state, header capture, interface tracking
// and endpoint selection, one byte per step. Depends on ucd_pkg.
`default_nettype none

module ucd_parse_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire ucd_pkg::in_item_t item,
    input  wire ucd_pkg::match_t   match,
    output ucd_pkg::result_t       res
);
    import ucd_pkg::*;

    // Walk state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [7:0]       dlen_reg, dlen_next;
    logic [7:0]       dtype_reg, dtype_next;
    logic             stopped_reg, stopped_next;
    logic [7:0]       hdr_reg [4];
    logic [7:0]       hdr_next [4];
    logic [7:0]       cur_if_reg [4];
    logic [7:0]       cur_if_next [4];
    logic [7:0]       scratch_reg [6];
    logic [7:0]       scratch_next [6];
    pick_t            pref_reg, pref_next;
    pick_t            fb_reg, fb_next;
    logic [7:0]       first_reg [3];
    logic [7:0]       first_next [3];

    // Per-step working values
    logic [7:0]       b;
    logic             last;
    logic             in_range;
    logic             walk_on;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] pos_step;
    logic             walk_commit;
    logic             end_commit;
    logic             known;
    logic [15:0]      raw_len;
    logic [POS_W-1:0] total_len;
    logic             in_ep;
    logic             cls_hit;
    logic             full_hit;
    logic             intr_ep;
    pick_t            new_pick;
    pick_t            out_pick;

    assign b    = item.data_byte;
    assign last = item.last_byte;

    always_comb
    begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        dlen_next    = dlen_reg;
        dtype_next   = dtype_reg;
        stopped_next = stopped_reg;
        hdr_next     = hdr_reg;
        cur_if_next  = cur_if_reg;
        scratch_next = scratch_reg;
        pref_next    = pref_reg;
        fb_next      = fb_reg;
        first_next   = first_reg;
        in_ep        = 1'b0;
        cls_hit      = 1'b0;
        full_hit     = 1'b0;
        intr_ep      = 1'b0;

        in_range = pos_reg < POS_W'(MAX_BLOCK_BYTES);
        offset   = pos_reg - start_reg;
        walk_on  = in_range && !stopped_reg && (pos_reg >= start_reg);
        pos_step = in_range ? pos_reg + POS_W'(1) : pos_reg;

        // Header bytes 2..5
        if (in_range && pos_reg >= POS_W'(2) && pos_reg <= POS_W'(5))
        begin
            hdr_next[2'(pos_reg - POS_W'(2))] = b;
        end

        // Field capture within the current descriptor
        if (walk_on)
        begin
            if (offset == '0)
            begin
                if (b == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    dlen_next  = b;
                    dtype_next = 8'd0;
                    for (int i = 0; i < 6; i++)
                    begin
                        scratch_next[i] = 8'd0;
                    end
                end
            end
            else if (offset == POS_W'(1))
            begin
                dtype_next = b;
            end
            else if (offset <= POS_W'(7))
            begin
                scratch_next[3'(offset - POS_W'(2))] = b;
            end
        end

        // At most one descriptor completes per byte: on its own last byte,
        // or at the block end when the block stops inside it
        walk_commit = walk_on && !stopped_next &&
                      (({1'b0, offset} + (POS_W+1)'(1)) == (POS_W+1)'(dlen_next));
        end_commit  = last && !stopped_next && !walk_commit && (pos_step > start_reg);
        // Length is not final before header byte 3 unless the block ends
        known       = walk_commit ? ((pos_reg >= POS_W'(3)) || last) : 1'b1;

        raw_len   = {hdr_next[1], hdr_next[0]};
        total_len = (raw_len > 16'(MAX_BLOCK_BYTES)) ? POS_W'(MAX_BLOCK_BYTES)
                                                     : POS_W'(raw_len);

        // Candidate endpoint from the scratch bytes
        new_pick.valid = 1'b1;
        new_pick.num   = 4'(scratch_next[0] & EP_NUM_MASK);
        new_pick.pkt   = {scratch_next[3], scratch_next[2]};
        new_pick.ifnum = cur_if_reg[0];
        new_pick.ivl   = (scratch_next[4] != 8'd0) ? scratch_next[4] - 8'd1 : 8'd0;

        if (walk_commit || end_commit)
        begin
            if (known && (({1'b0, start_reg} + (POS_W+1)'(1)) >= {1'b0, total_len}))
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                if (dtype_next == DT_INTERFACE)
                begin
                    cur_if_next[0] = scratch_next[0];
                    cur_if_next[1] = scratch_next[3];
                    cur_if_next[2] = scratch_next[4];
                    cur_if_next[3] = scratch_next[5];
                    if (first_reg[0] == 8'd0)
                    begin
                        first_next[0] = scratch_next[3];
                        first_next[1] = scratch_next[4];
                        first_next[2] = scratch_next[5];
                    end
                end
                else if (dtype_next == DT_ENDPOINT)
                begin
                    in_ep    = (scratch_next[0] & EP_DIR_IN) != 8'd0;
                    cls_hit  = cur_if_reg[1] == match.cls;
                    full_hit = cls_hit && (cur_if_reg[2] == match.subclass) &&
                               (cur_if_reg[3] == match.protocol);
                    intr_ep  = (scratch_next[1] & XFER_MASK) == XFER_INTERRUPT;
                    if (in_ep && !pref_reg.valid && full_hit)
                    begin
                        pref_next = new_pick;
                    end
                    else if (in_ep && !pref_reg.valid && !fb_reg.valid && cls_hit && intr_ep)
                    begin
                        fb_next = new_pick;
                    end
                end
                start_next = start_reg + POS_W'(dlen_next);
            end
        end
        pos_next = pos_step;

        // Result fields from the state after this byte
        out_pick = pref_next.valid ? pref_next : fb_next;
        res.choice = pref_next.valid ? CHOICE_PREFER :
                     (fb_next.valid ? CHOICE_FALLBACK : CHOICE_NONE);
        if (pref_next.valid || fb_next.valid)
        begin
            res.endpoint_number  = out_pick.num;
            res.endpoint_id      = {out_pick.num, 1'b1};
            res.max_packet       = out_pick.pkt;
            res.interface_number = out_pick.ifnum;
            res.poll_interval    = out_pick.ivl;
        end
        else
        begin
            res.endpoint_number  = 4'd0;
            res.endpoint_id      = 5'd0;
            res.max_packet       = 16'd0;
            res.interface_number = NO_INTERFACE;
            res.poll_interval    = 8'd0;
        end
        res.total_length        = TOTAL_LEN_W'(total_len);
        res.interface_count     = hdr_next[2];
        res.configuration_value = (hdr_next[3] == 8'd0) ? 8'd1 : hdr_next[3];
        res.first_class         = first_next[0];
        res.first_subclass      = first_next[1];
        res.first_protocol      = first_next[2];
    end

    // State update; the last byte starts a fresh block, but the first-interface capture is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            start_reg   <= '0;
            dlen_reg    <= 8'd0;
            dtype_reg   <= 8'd0;
            stopped_reg <= 1'b0;
            hdr_reg     <= '{default: 8'd0};
            cur_if_reg  <= '{default: 8'd0};
            scratch_reg <= '{default: 8'd0};
            pref_reg    <= '0;
            fb_reg      <= '{valid: 1'b0, num: 4'd0, pkt: 16'd0, ifnum: NO_INTERFACE,
                             ivl: 8'd0};
            first_reg   <= '{default: 8'd0};
        end
        else if (step)
        begin
            first_reg <= first_next;
            if (last)
            begin
                pos_reg     <= '0;
                start_reg   <= '0;
                dlen_reg    <= 8'd0;
                dtype_reg   <= 8'd0;
                stopped_reg <= 1'b0;
                hdr_reg     <= '{default: 8'd0};
                cur_if_reg  <= '{default: 8'd0};
                scratch_reg <= '{default: 8'd0};
                pref_reg    <= '0;
                fb_reg      <= '{valid: 1'b0, num: 4'd0, pkt: 16'd0, ifnum: NO_INTERFACE,
                                 ivl: 8'd0};
            end
            else
            begin
                pos_reg     <= pos_next;
                start_reg   <= start_next;
                dlen_reg    <= dlen_next;
                dtype_reg   <= dtype_next;
                stopped_reg <= stopped_next;
                hdr_reg     <= hdr_next;
                cur_if_reg  <= cur_if_next;
                scratch_reg <= scratch_next;
                pref_reg    <= pref_next;
                fb_reg      <= fb_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/ucd_out_stage.sv]
// ucd_out_stage: result register driving the output channel.
// Depends on ucd_pkg and ucd_result_if.
`default_nettype none

module ucd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ucd_pkg::result_t res,
    output logic                  busy,
    ucd_result_if.source          result
);
    import ucd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign busy                       = valid_reg;
    assign result.valid               = valid_reg;
    assign result.choice              = res_reg.choice;
    assign result.endpoint_number     = res_reg.endpoint_number;
    assign result.endpoint_id         = res_reg.endpoint_id;
    assign result.max_packet          = res_reg.max_packet;
    assign result.interface_number    = res_reg.interface_number;
    assign result.poll_interval       = res_reg.poll_interval;
    assign result.total_length        = res_reg.total_length;
    assign result.interface_count     = res_reg.interface_count;
    assign result.configuration_value = res_reg.configuration_value;
    assign result.first_class         = res_reg.first_class;
    assign result.first_subclass      = res_reg.first_subclass;
    assign result.first_protocol      = res_reg.first_protocol;

endmodule

`default_nettype wire
